### hdl/fpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared widths, operation codes and pipeline sideband for the Q24.8 ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 8;
  localparam int KIND_BITS = 4;
  // dividend after the fraction shift, one divider stage per bit
  localparam int DIV_BITS  = WORD_BITS + FRAC_BITS;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_ADD = 4'd0,
    KIND_SUB = 4'd1,
    KIND_MUL = 4'd2,
    KIND_DIV = 4'd3,
    KIND_INC = 4'd4,
    KIND_DEC = 4'd5,
    KIND_GT  = 4'd6,
    KIND_LT  = 4'd7,
    KIND_GE  = 4'd8,
    KIND_LE  = 4'd9,
    KIND_EQ  = 4'd10,
    KIND_NE  = 4'd11
  } fpa_kind_t;

  // everything that rides beside the divider datapath
  typedef struct packed {
    logic                 is_div;
    logic                 neg;
    logic                 dz;
    logic                 cmp;
    logic [WORD_BITS-1:0] value;
  } fpa_side_t;

endpackage

### hdl/fixed_point_alu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_core
// Signed Q24.8 ALU: add, sub, mul, div, inc, dec and six compares.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_kind, in_operand_a and in_operand_b with start high; the beat is
//   taken at the edge where start is high and busy is low. busy stays low, so
//   a new beat may be issued on every clock.
//   Every beat gives exactly one result beat, shown for one cycle with
//   out_valid high: out_result_value, out_compare_true, out_divide_by_zero.
//   Every operation passes through the same registers, whatever its kind.
//   Throughput is one beat per cycle. The depth is set by the divider,
//   which resolves one quotient bit per stage over 40 stages (32 word bits
//   plus 8 fraction bits); an input register and an operand stage holding
//   the 32x32 multiplier come before it and an output register after it.
//   All other operations travel alongside the divider with the same latency,
//   so results leave in issue order.
//   Synchronous reset drops every beat in flight; no results follow it.
//   The receiver must take every result in its cycle; there is no back
//   pressure on the result side.
// ----------------------------------------------------------------------------
module fixed_point_alu_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [fpa_pkg::KIND_BITS-1:0]        in_kind,
  input  logic signed [fpa_pkg::WORD_BITS-1:0] in_operand_a,
  input  logic signed [fpa_pkg::WORD_BITS-1:0] in_operand_b,
  output logic                                 out_valid,
  output logic signed [fpa_pkg::WORD_BITS-1:0] out_result_value,
  output logic                                 out_compare_true,
  output logic                                 out_divide_by_zero
);
  import fpa_pkg::*;

  // input register
  logic                        s0_valid_r;
  logic [KIND_BITS-1:0]        s0_kind_r;
  logic signed [WORD_BITS-1:0] s0_a_r;
  logic signed [WORD_BITS-1:0] s0_b_r;

  // operand stage
  logic                          s1_valid_r;
  logic                          s1_is_mul_r, s1_is_mul_nxt;
  logic                          s1_is_div_r, s1_is_div_nxt;
  logic                          s1_neg_r,    s1_neg_nxt;
  logic                          s1_dz_r,     s1_dz_nxt;
  logic                          s1_cmp_r,    s1_cmp_nxt;
  logic [WORD_BITS-1:0]          s1_value_r,  s1_value_nxt;
  logic signed [2*WORD_BITS-1:0] s1_prod_r,   s1_prod_nxt;
  logic [DIV_BITS-1:0]           s1_dvd_r,    s1_dvd_nxt;
  logic [WORD_BITS-1:0]          s1_dsr_r,    s1_dsr_nxt;

  logic [WORD_BITS-1:0] mag_a;
  fpa_side_t            div_side_in;
  logic                 div_valid;
  logic [WORD_BITS-1:0] div_quotient;
  fpa_side_t            div_side;

  logic                        out_valid_r;
  logic signed [WORD_BITS-1:0] out_value_r, out_value_nxt;
  logic                        out_cmp_r;
  logic                        out_dz_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_kind_r <= in_kind;
    s0_a_r    <= in_operand_a;
    s0_b_r    <= in_operand_b;
  end

  assign mag_a = s0_a_r[WORD_BITS-1] ? WORD_BITS'(-s0_a_r) : WORD_BITS'(s0_a_r);

  always_comb begin
    s1_value_nxt  = '0;
    s1_cmp_nxt    = 1'b0;
    s1_is_mul_nxt = 1'b0;
    s1_is_div_nxt = 1'b0;
    s1_dz_nxt     = 1'b0;
    case (s0_kind_r)
      KIND_ADD: s1_value_nxt  = WORD_BITS'(s0_a_r + s0_b_r);
      KIND_SUB: s1_value_nxt  = WORD_BITS'(s0_a_r - s0_b_r);
      KIND_MUL: s1_is_mul_nxt = 1'b1;
      KIND_DIV: begin
        s1_is_div_nxt = 1'b1;
        s1_dz_nxt     = (s0_b_r == '0);
      end
      KIND_INC: s1_value_nxt = WORD_BITS'(s0_a_r + WORD_BITS'(1));
      KIND_DEC: s1_value_nxt = WORD_BITS'(s0_a_r - WORD_BITS'(1));
      KIND_GT:  s1_cmp_nxt   = (s0_a_r >  s0_b_r);
      KIND_LT:  s1_cmp_nxt   = (s0_a_r <  s0_b_r);
      KIND_GE:  s1_cmp_nxt   = (s0_a_r >= s0_b_r);
      KIND_LE:  s1_cmp_nxt   = (s0_a_r <= s0_b_r);
      KIND_EQ:  s1_cmp_nxt   = (s0_a_r == s0_b_r);
      KIND_NE:  s1_cmp_nxt   = (s0_a_r != s0_b_r);
      default:  s1_value_nxt = '0;
    endcase
  end

  assign s1_prod_nxt = (2*WORD_BITS)'(s0_a_r) * (2*WORD_BITS)'(s0_b_r);
  assign s1_neg_nxt  = s0_a_r[WORD_BITS-1] ^ s0_b_r[WORD_BITS-1];
  assign s1_dvd_nxt  = DIV_BITS'(mag_a) << FRAC_BITS;
  assign s1_dsr_nxt  = s0_b_r[WORD_BITS-1] ? WORD_BITS'(-s0_b_r) : WORD_BITS'(s0_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_is_mul_r <= s1_is_mul_nxt;
    s1_is_div_r <= s1_is_div_nxt;
    s1_neg_r    <= s1_neg_nxt;
    s1_dz_r     <= s1_dz_nxt;
    s1_cmp_r    <= s1_cmp_nxt;
    s1_value_r  <= s1_value_nxt;
    s1_prod_r   <= s1_prod_nxt;
    s1_dvd_r    <= s1_dvd_nxt;
    s1_dsr_r    <= s1_dsr_nxt;
  end

  // drop the fraction bits of the product on the way into the divider stages
  always_comb begin
    div_side_in.is_div = s1_is_div_r;
    div_side_in.neg    = s1_neg_r;
    div_side_in.dz     = s1_dz_r;
    div_side_in.cmp    = s1_cmp_r;
    div_side_in.value  = s1_is_mul_r ? s1_prod_r[FRAC_BITS+WORD_BITS-1:FRAC_BITS]
                                     : s1_value_r;
  end

  fpa_div u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (s1_valid_r),
    .in_dividend  (s1_dvd_r),
    .in_divisor   (s1_dsr_r),
    .in_side      (div_side_in),
    .out_valid    (div_valid),
    .out_quotient (div_quotient),
    .out_side     (div_side)
  );

  always_comb begin
    if (!div_side.is_div) begin
      out_value_nxt = div_side.value;
    end else if (div_side.dz) begin
      out_value_nxt = '0;
    end else if (div_side.neg) begin
      out_value_nxt = WORD_BITS'(-div_quotient);
    end else begin
      out_value_nxt = div_quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_cmp_r   <= div_side.cmp;
    out_dz_r    <= div_side.dz;
  end

  assign out_valid          = out_valid_r;
  assign out_result_value   = out_value_r;
  assign out_compare_true   = out_cmp_r;
  assign out_divide_by_zero = out_dz_r;

`ifndef SYNTHESIS
  a_dz_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_result_value == '0 && !out_compare_true)
    else $error("divide by zero beat carries a nonzero result");

  a_cmp_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |-> out_result_value == '0 && !out_divide_by_zero)
    else $error("compare beat carries arithmetic result bits");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(s1_valid_r, DIV_BITS + 1))
    else $error("result beat without a matching operand stage beat");
`endif

endmodule

### hdl/fpa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_div
// Fully pipelined unsigned restoring divider, one quotient bit per stage.
// Keeps the low WORD_BITS of the quotient and carries a sideband alongside.
// ----------------------------------------------------------------------------
module fpa_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [fpa_pkg::DIV_BITS-1:0]  in_dividend,
  input  logic [fpa_pkg::WORD_BITS-1:0] in_divisor,
  input  fpa_pkg::fpa_side_t            in_side,
  output logic                          out_valid,
  output logic [fpa_pkg::WORD_BITS-1:0] out_quotient,
  output fpa_pkg::fpa_side_t            out_side
);
  import fpa_pkg::*;

  logic                 valid_r [DIV_BITS];
  logic [WORD_BITS-1:0] rem_r   [DIV_BITS];
  logic [DIV_BITS-1:0]  dvd_r   [DIV_BITS];
  logic [WORD_BITS-1:0] dsr_r   [DIV_BITS];
  logic [WORD_BITS-1:0] quo_r   [DIV_BITS];
  fpa_side_t            side_r  [DIV_BITS];

  for (genvar g = 0; g < DIV_BITS; g++) begin : g_step
    logic                 v_in;
    logic [WORD_BITS-1:0] rem_in;
    logic [DIV_BITS-1:0]  dvd_in;
    logic [WORD_BITS-1:0] dsr_in;
    logic [WORD_BITS-1:0] quo_in;
    fpa_side_t            side_in;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   diff;
    logic                 take;

    if (g == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign dvd_in  = in_dividend;
      assign dsr_in  = in_divisor;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = valid_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign dvd_in  = dvd_r[g-1];
      assign dsr_in  = dsr_r[g-1];
      assign quo_in  = quo_r[g-1];
      assign side_in = side_r[g-1];
    end

    // bring down the next dividend bit and try the subtract
    assign trial = {rem_in, dvd_in[DIV_BITS-1]};
    assign diff  = trial - {1'b0, dsr_in};
    assign take  = (trial >= {1'b0, dsr_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else begin
        valid_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[g]  <= take ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      dvd_r[g]  <= {dvd_in[DIV_BITS-2:0], 1'b0};
      dsr_r[g]  <= dsr_in;
      quo_r[g]  <= {quo_in[WORD_BITS-2:0], take};
      side_r[g] <= side_in;
    end
  end

  assign out_valid    = valid_r[DIV_BITS-1];
  assign out_quotient = quo_r[DIV_BITS-1];
  assign out_side     = side_r[DIV_BITS-1];

endmodule
